FILE: rtl/core/iee_pkg.sv
// Package for the infix expression evaluator.
// Holds character classes and codes, operator and status codes, sequencer states and reduce modes.
// No dependencies.
package iee_pkg;

  typedef enum logic [2:0] {
    CLS_START = 3'd0,
    CLS_DIGIT = 3'd1,
    CLS_OPER  = 3'd2,
    CLS_OPEN  = 3'd3,
    CLS_CLOSE = 3'd4
  } cls_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SYNTAX   = 3'd1,
    ST_BRACKET  = 3'd2,
    ST_DIVZERO  = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL   = 3'd2,
    OP_DIV   = 3'd3,
    OP_PAREN = 3'd4,
    OP_BRACK = 3'd5,
    OP_BRACE = 3'd6
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIGIT,
    S_REDUCE,
    S_POP_B,
    S_POP_A,
    S_EXEC,
    S_DIV,
    S_PUSH_R,
    S_AFTER,
    S_FINAL,
    S_RESULT,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    RD_OPER,
    RD_CLOSE,
    RD_END
  } reduce_t;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_LBRC  = 8'h7B;
  localparam logic [7:0] CH_RBRC  = 8'h7D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam int         RADIX    = 10;

endpackage

FILE: rtl/core/iee_if.sv
// Valid/ready channel interfaces for the infix expression evaluator.
// Depends on nothing; payload widths are fixed by the item format.
interface iee_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;
  modport source (output valid, output char_code, output last_char, input ready);
  modport sink (input valid, input char_code, input last_char, output ready);
endinterface

interface iee_out_if;
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic signed [31:0] result_value;
  modport source (output valid, output status, output result_value, input ready);
  modport sink (input valid, input status, input result_value, output ready);
endinterface

FILE: rtl/core/infix_expression_evaluator.sv
// Infix expression evaluator: one ASCII character per input transfer.
// Channels: in (char_code, last_char) and out (status, result_value), both
// valid/ready; an item moves on a clock edge with valid and ready both high.
// A result transfer follows only an input item marked last_char.
// Operands and operators sit in two stack memories; one shared ALU (add,
// subtract, multiply, or one restoring-division step per cycle) does the work
// under a sequencer; each stack has one write port and a registered read of its top.
// An ignored character or an opening bracket is done in S_IDLE, a digit passes
// S_DIGIT, a leading sign S_AFTER, an operator or closing bracket S_REDUCE and
// S_AFTER plus S_POP_B, S_POP_A, S_EXEC and S_PUSH_R for each operator reduced;
// a division runs S_DIV once per quotient bit. The last character then passes
// S_FINAL, the final reduction, S_RESULT and S_OUT before the result is valid.
// in_ready is high only while the sequencer is idle.
// Reset (rst_n low, synchronous) empties both stacks and clears the error.
// When the receiver stalls the result is held in the output register and no
// new character is taken until it has been transferred.
// The first error found is kept; later characters are skipped until the last.
module infix_expression_evaluator
  import iee_pkg::*;
#(
  parameter int STACK_DEPTH = 16,
  parameter int VALUE_WIDTH = 32
) (
  input logic clk,
  input logic rst_n,
  iee_in_if.sink in_ch,
  iee_out_if.source out_ch
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DCW = $clog2(VALUE_WIDTH + 1);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  // Stack memories, each with one write port and one registered read port.
  logic [VALUE_WIDTH-1:0] opnd_mem [STACK_DEPTH];
  logic [2:0]             oper_mem [STACK_DEPTH];

  state_t  state_r, state_nxt;
  reduce_t mode_r, mode_nxt;
  logic [CW-1:0] opnd_cnt_r, opnd_cnt_nxt, oper_cnt_r, oper_cnt_nxt;
  logic [VALUE_WIDTH-1:0] acc_r, acc_nxt;
  cls_t    prev_r, prev_nxt;
  status_t err_r, err_nxt;
  logic [2:0] pend_op_r, pend_op_nxt;
  logic    last_r, last_nxt;
  logic [VALUE_WIDTH-1:0] a_r, a_nxt, b_r, b_nxt, res_r, res_nxt;
  logic [VALUE_WIDTH-1:0] rem_r, rem_nxt, quo_r, quo_nxt;
  logic [DCW-1:0] dcnt_r, dcnt_nxt;
  logic [2:0] top_op_r;
  logic [2:0] app_op_r, app_op_nxt;
  logic [VALUE_WIDTH-1:0] top_val_r;
  logic    out_valid_r, out_valid_nxt;
  logic [2:0] out_status_r, out_status_nxt;
  logic [31:0] out_value_r, out_value_nxt;

  // Memory ports.
  logic opnd_we, oper_we;
  logic [AW-1:0] opnd_waddr, opnd_raddr, oper_waddr, oper_raddr;
  logic [VALUE_WIDTH-1:0] opnd_wdata;
  logic [2:0] oper_wdata;

  // Character decode.
  logic [7:0] ch;
  logic is_digit, is_oper, is_open, is_close;
  logic [2:0] ch_op;
  assign ch = in_ch.char_code;
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_oper = (ch == CH_PLUS) || (ch == CH_MINUS) || (ch == CH_STAR) || (ch == CH_SLASH);
  assign is_open = (ch == CH_LPAR) || (ch == CH_LBRK) || (ch == CH_LBRC);
  assign is_close = (ch == CH_RPAR) || (ch == CH_RBRK) || (ch == CH_RBRC);

  always_comb begin
    case (ch)
      CH_PLUS:  ch_op = OP_ADD;
      CH_MINUS: ch_op = OP_SUB;
      CH_STAR:  ch_op = OP_MUL;
      CH_SLASH: ch_op = OP_DIV;
      CH_LPAR, CH_RPAR: ch_op = OP_PAREN;
      CH_LBRK, CH_RBRK: ch_op = OP_BRACK;
      default:  ch_op = OP_BRACE;
    endcase
  end

  // Signed helpers for the division unit.
  logic a_neg, b_neg;
  logic [VALUE_WIDTH-1:0] mag_a, mag_b;
  logic [VALUE_WIDTH:0] trial;
  assign a_neg = a_r[VALUE_WIDTH-1];
  assign b_neg = b_r[VALUE_WIDTH-1];
  assign mag_a = a_neg ? (~a_r + 1'b1) : a_r;
  assign mag_b = b_neg ? (~b_r + 1'b1) : b_r;
  assign trial = {rem_r, quo_r[VALUE_WIDTH-1]} - {1'b0, mag_b};

  logic in_fire;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && !out_valid_r;

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    mode_nxt = mode_r;
    opnd_cnt_nxt = opnd_cnt_r;
    oper_cnt_nxt = oper_cnt_r;
    acc_nxt = acc_r;
    prev_nxt = prev_r;
    err_nxt = err_r;
    pend_op_nxt = pend_op_r;
    last_nxt = last_r;
    a_nxt = a_r;
    b_nxt = b_r;
    res_nxt = res_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    dcnt_nxt = dcnt_r;
    app_op_nxt = app_op_r;
    out_valid_nxt = out_valid_r;
    out_status_nxt = out_status_r;
    out_value_nxt = out_value_r;
    opnd_we = 1'b0;
    oper_we = 1'b0;
    opnd_waddr = opnd_cnt_r[AW-1:0];
    opnd_wdata = acc_r;
    oper_waddr = oper_cnt_r[AW-1:0];
    oper_wdata = pend_op_r;
    opnd_raddr = opnd_cnt_r[AW-1:0] - 1'b1;
    oper_raddr = oper_cnt_r[AW-1:0] - 1'b1;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          last_nxt = in_ch.last_char;
          pend_op_nxt = ch_op;
          state_nxt = in_ch.last_char ? S_FINAL : S_IDLE;
          if (err_r == ST_OK) begin
            if (is_digit) begin
              if (prev_r == CLS_CLOSE) begin
                err_nxt = ST_SYNTAX;
              end else begin
                // Digit work finishes in S_DIGIT.
                acc_nxt = (prev_r == CLS_DIGIT && opnd_cnt_r != '0)
                          ? acc_r * VALUE_WIDTH'(RADIX) + VALUE_WIDTH'(ch - CH_ZERO)
                          : VALUE_WIDTH'(ch - CH_ZERO);
                a_nxt = {VALUE_WIDTH{(prev_r == CLS_DIGIT && opnd_cnt_r != '0)}};
                prev_nxt = CLS_DIGIT;
                state_nxt = S_DIGIT;
              end
            end else if (is_oper) begin
              if (prev_r == CLS_START && (ch_op == OP_ADD || ch_op == OP_SUB)) begin
                // Unary sign: push zero, then the operator.
                if (opnd_cnt_r >= FULL) begin
                  err_nxt = ST_OVERFLOW;
                end else begin
                  opnd_we = 1'b1;
                  opnd_wdata = '0;
                  opnd_cnt_nxt = opnd_cnt_r + 1'b1;
                  mode_nxt = RD_OPER;
                  state_nxt = S_AFTER;
                end
              end else if (prev_r == CLS_DIGIT || prev_r == CLS_CLOSE) begin
                mode_nxt = RD_OPER;
                state_nxt = S_REDUCE;
              end else begin
                err_nxt = ST_SYNTAX;
              end
            end else if (is_open) begin
              if (prev_r == CLS_DIGIT || prev_r == CLS_CLOSE) begin
                err_nxt = ST_SYNTAX;
              end else if (oper_cnt_r >= FULL) begin
                err_nxt = ST_OVERFLOW;
              end else begin
                oper_we = 1'b1;
                oper_wdata = ch_op;
                oper_cnt_nxt = oper_cnt_r + 1'b1;
                prev_nxt = CLS_OPEN;
              end
            end else if (is_close) begin
              if (prev_r != CLS_DIGIT && prev_r != CLS_CLOSE) begin
                err_nxt = ST_SYNTAX;
              end else begin
                mode_nxt = RD_CLOSE;
                state_nxt = S_REDUCE;
              end
            end
          end
        end
      end

      // Write the number to the top (replace) or push it.
      S_DIGIT: begin
        if (a_r[0]) begin
          opnd_we = 1'b1;
          opnd_waddr = opnd_cnt_r[AW-1:0] - 1'b1;
        end else if (opnd_cnt_r >= FULL) begin
          err_nxt = ST_OVERFLOW;
        end else begin
          opnd_we = 1'b1;
          opnd_cnt_nxt = opnd_cnt_r + 1'b1;
        end
        state_nxt = last_r ? S_FINAL : S_IDLE;
      end

      // Decide whether the top operator is applied; top_op_r follows the stack top.
      S_REDUCE: begin
        if (err_r != ST_OK) begin
          if (mode_r == RD_END) begin
            state_nxt = S_RESULT;
          end else begin
            state_nxt = last_r ? S_FINAL : S_IDLE;
          end
        end else if (mode_r == RD_END) begin
          if (oper_cnt_r == '0) begin
            state_nxt = S_RESULT;
          end else if (top_op_r >= OP_PAREN) begin
            err_nxt = ST_BRACKET;
            state_nxt = S_RESULT;
          end else begin
            state_nxt = S_POP_B;
          end
        end else if (oper_cnt_r != '0 && top_op_r < OP_PAREN &&
                     (mode_r == RD_CLOSE || top_op_r[2:1] >= pend_op_r[2:1])) begin
          state_nxt = S_POP_B;
        end else begin
          state_nxt = S_AFTER;
        end
      end

      // Take the right operand; start the read of the left one below it.
      S_POP_B: begin
        opnd_raddr = opnd_cnt_r[AW-1:0] - AW'(2);
        if (opnd_cnt_r < CW'(2)) begin
          err_nxt = ST_SYNTAX;
          state_nxt = S_REDUCE;
        end else begin
          app_op_nxt = top_op_r;
          oper_cnt_nxt = oper_cnt_r - 1'b1;
          opnd_cnt_nxt = opnd_cnt_r - 1'b1;
          b_nxt = top_val_r;
          state_nxt = S_POP_A;
        end
      end

      S_POP_A: begin
        opnd_cnt_nxt = opnd_cnt_r - 1'b1;
        a_nxt = top_val_r;
        state_nxt = S_EXEC;
      end

      S_EXEC: begin
        case (app_op_r)
          OP_ADD: begin
            res_nxt = a_r + b_r;
            state_nxt = S_PUSH_R;
          end
          OP_SUB: begin
            res_nxt = a_r - b_r;
            state_nxt = S_PUSH_R;
          end
          OP_MUL: begin
            res_nxt = a_r * b_r;
            state_nxt = S_PUSH_R;
          end
          default: begin
            if (b_r == '0) begin
              err_nxt = ST_DIVZERO;
              state_nxt = S_REDUCE;
            end else begin
              rem_nxt = '0;
              quo_nxt = mag_a;
              dcnt_nxt = DCW'(VALUE_WIDTH);
              state_nxt = S_DIV;
            end
          end
        endcase
      end

      // One restoring-division step per cycle.
      S_DIV: begin
        if (dcnt_r == '0) begin
          res_nxt = (a_neg ^ b_neg) ? (~quo_r + 1'b1) : quo_r;
          state_nxt = S_PUSH_R;
        end else begin
          if (!trial[VALUE_WIDTH]) begin
            rem_nxt = trial[VALUE_WIDTH-1:0];
            quo_nxt = {quo_r[VALUE_WIDTH-2:0], 1'b1};
          end else begin
            rem_nxt = {rem_r[VALUE_WIDTH-2:0], quo_r[VALUE_WIDTH-1]};
            quo_nxt = {quo_r[VALUE_WIDTH-2:0], 1'b0};
          end
          dcnt_nxt = dcnt_r - 1'b1;
        end
      end

      // Push the result; the two pops leave room for it.
      S_PUSH_R: begin
        opnd_we = 1'b1;
        opnd_wdata = res_r;
        opnd_cnt_nxt = opnd_cnt_r + 1'b1;
        state_nxt = S_REDUCE;
      end

      // Finish an operator (push it) or a closing bracket (pop its match).
      S_AFTER: begin
        if (err_r != ST_OK) begin
          state_nxt = last_r ? S_FINAL : S_IDLE;
        end else if (mode_r == RD_OPER) begin
          if (oper_cnt_r >= FULL) begin
            err_nxt = ST_OVERFLOW;
          end else begin
            oper_we = 1'b1;
            oper_cnt_nxt = oper_cnt_r + 1'b1;
            prev_nxt = CLS_OPER;
          end
          state_nxt = last_r ? S_FINAL : S_IDLE;
        end else begin
          if (oper_cnt_r == '0 || top_op_r != pend_op_r) begin
            err_nxt = ST_BRACKET;
          end else begin
            oper_cnt_nxt = oper_cnt_r - 1'b1;
            prev_nxt = CLS_CLOSE;
          end
          state_nxt = last_r ? S_FINAL : S_IDLE;
        end
      end

      S_FINAL: begin
        mode_nxt = RD_END;
        last_nxt = 1'b0;
        if (err_r == ST_OK && prev_r != CLS_DIGIT && prev_r != CLS_CLOSE) begin
          err_nxt = ST_SYNTAX;
          state_nxt = S_RESULT;
        end else if (err_r != ST_OK) begin
          state_nxt = S_RESULT;
        end else begin
          state_nxt = S_REDUCE;
        end
      end

      // top_val_r holds the top operand here.
      S_RESULT: begin
        if (err_r == ST_OK && opnd_cnt_r == '0) err_nxt = ST_SYNTAX;
        state_nxt = S_OUT;
      end

      S_OUT: begin
        out_valid_nxt = 1'b1;
        out_status_nxt = err_r;
        out_value_nxt = (err_r == ST_OK) ? 32'(signed'(top_val_r)) : '0;
        opnd_cnt_nxt = '0;
        oper_cnt_nxt = '0;
        acc_nxt = '0;
        prev_nxt = CLS_START;
        err_nxt = ST_OK;
        state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Stack memories with registered reads of both tops.
  always_ff @(posedge clk) begin
    if (opnd_we) opnd_mem[opnd_waddr] <= opnd_wdata;
    if (oper_we) oper_mem[oper_waddr] <= oper_wdata;
    top_val_r <= opnd_mem[opnd_raddr];
    top_op_r <= oper_mem[oper_raddr];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      opnd_cnt_r <= '0;
      oper_cnt_r <= '0;
      prev_r <= CLS_START;
      err_r <= ST_OK;
      last_r <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r <= '0;
    end else begin
      state_r <= state_nxt;
      opnd_cnt_r <= opnd_cnt_nxt;
      oper_cnt_r <= oper_cnt_nxt;
      prev_r <= prev_nxt;
      err_r <= err_nxt;
      last_r <= last_nxt;
      out_valid_r <= out_valid_nxt;
      acc_r <= acc_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    pend_op_r <= pend_op_nxt;
    a_r <= a_nxt;
    b_r <= b_nxt;
    res_r <= res_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dcnt_r <= dcnt_nxt;
    app_op_r <= app_op_nxt;
    out_status_r <= out_status_nxt;
    out_value_r <= out_value_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.result_value = out_value_r;

endmodule

FILE: rtl/core/iee_checker.sv
// Port-level checker for the infix expression evaluator.
// Depends on iee_pkg; bound to infix_expression_evaluator below.
module iee_checker
  import iee_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [31:0] out_value
);

  // A held result keeps its payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_status) && $stable(out_value))
    else $error("result changed while stalled");

  // No new character while a result waits.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while result pending");

  // An error result carries a zero value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_value == '0)
    else $error("error result with nonzero value");

  // Status codes stay within the defined set.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_OVERFLOW)
    else $error("undefined status");

endmodule

bind infix_expression_evaluator iee_checker u_iee_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_status(out_ch.status), .out_value(out_ch.result_value)
);
